// ===== design/srfe_pkg.sv =====
package srfe_pkg;

  // Request codes on req_type
  typedef enum logic [2:0] {
    REQ_START_WRITE = 3'd0,
    REQ_WRITE_DATA  = 3'd1,
    REQ_START_READ  = 3'd2,
    REQ_RX_BYTE     = 3'd3,
    REQ_TICK        = 3'd4
  } req_e;

  // Result kinds on result_kind
  typedef enum logic [1:0] {
    KIND_TX_BYTE  = 2'd0,
    KIND_RX_DATA  = 2'd1,
    KIND_MISSED   = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  // Read status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_NONE     = 2'd3
  } status_e;

  // Transaction phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  localparam logic [7:0] CmdWriteBit  = 8'h80;
  localparam logic [9:0] TimeoutReset = 10'd100;
  localparam logic [2:0] MaxLen       = 3'd4;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QAw         = $clog2(QDepth);

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [1:0]  index;
    status_e     status;
    logic        last;
  } result_t;

  // One accepted item's results: one or two
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  // Queue status seen by the top level and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/serial_register_frame_engine.sv =====
// Register-access frame engine, host side. Requests come in through a queue
// style port (push/full) and results leave through another (empty/pop); a
// request is taken every cycle while full is low. A start write yields the
// command byte, each write data byte yields itself, and the final data byte
// (or a zero-length start) also yields the inverted-sum checksum with last
// set. Read requests yield the address byte, then received data, missed
// slots and a finish with its read status. A four-entry queue sits between
// the request decoder and the output register, so requests keep flowing
// while results are held by the consumer. Results drain at one per cycle
// while popped; a two-result request yields first, then second result. The
// timeout register is written through cfg_valid_i/cfg_data_i, always ready.
module serial_register_frame_engine import srfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type_i,
  input  logic [6:0] reg_addr_i,
  input  logic [2:0] length_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] result_kind_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] byte_index_o,
  output logic [1:0] read_status_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i
);

  logic      accept;
  logic      enq;
  logic      deq;
  entry_t    enq_entry;
  entry_t    head;
  q_status_t q_status;
  result_t   result;

  assign full        = q_status.full;
  assign accept      = push && !q_status.full;
  assign cfg_ready_o = 1'b1;

  srfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .reg_addr_i  (reg_addr_i),
    .length_i    (length_i),
    .data_byte_i (data_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .enq_o       (enq),
    .entry_o     (enq_entry)
  );

  srfe_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (enq),
    .wr_data_i (enq_entry),
    .rd_i      (deq),
    .rd_data_o (head),
    .status_o  (q_status)
  );

  srfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .deq_o      (deq),
    .pop        (pop),
    .empty      (empty),
    .result_o   (result)
  );

  assign result_kind_o = result.kind;
  assign byte_value_o  = result.value;
  assign byte_index_o  = result.index;
  assign read_status_o = result.status;
  assign last_o        = result.last;

endmodule

// ===== design/srfe_front.sv =====
module srfe_front import srfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [2:0] req_type_i,
  input  logic [6:0] reg_addr_i,
  input  logic [2:0] length_i,
  input  logic [7:0] data_byte_i,
  input  logic       cfg_valid_i,
  input  logic [9:0] cfg_data_i,
  output logic       enq_o,
  output entry_t     entry_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [2:0] len_q, len_d;
  logic [2:0] slot_q, slot_d;
  logic [9:0] wait_q, wait_d;
  logic [9:0] timeout_q;

  logic [2:0] len_sat;
  logic [7:0] cmd_byte;
  logic [7:0] sum_add;
  logic [2:0] slot_inc;
  result_t    res_a, res_b;

  assign len_sat  = (length_i > MaxLen) ? MaxLen : length_i;
  assign cmd_byte = {1'b0, reg_addr_i} | CmdWriteBit;
  assign sum_add  = sum_q + data_byte_i;
  assign slot_inc = slot_q + 3'd1;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sum_q   <= '0;
      len_q   <= '0;
      slot_q  <= '0;
      wait_q  <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      slot_q  <= slot_d;
      wait_q  <= wait_d;
    end
  end

  // Classify the request, update state, build its results
  always_comb begin
    phase_d = phase_q;
    sum_d   = sum_q;
    len_d   = len_q;
    slot_d  = slot_q;
    wait_d  = wait_q;
    enq_o   = 1'b0;
    res_a   = '{kind: KIND_TX_BYTE, value: '0, index: '0, status: ST_NONE, last: 1'b0};
    res_b   = res_a;
    entry_o = '{first: res_a, second: res_b, two: 1'b0};
    if (accept_i) begin
      unique case (req_type_i)
        REQ_START_WRITE: begin
          enq_o       = 1'b1;
          res_a.value = cmd_byte;
          sum_d       = cmd_byte;
          len_d       = len_sat;
          slot_d      = '0;
          wait_d      = '0;
          phase_d     = PH_WRITE;
          if (len_sat == 3'd0) begin
            entry_o.two = 1'b1;
            res_b.value = ~cmd_byte;
            res_b.last  = 1'b1;
            phase_d     = PH_IDLE;
          end
        end
        REQ_WRITE_DATA: begin
          if (phase_q == PH_WRITE) begin
            enq_o       = 1'b1;
            res_a.value = data_byte_i;
            sum_d       = sum_add;
            slot_d      = slot_inc;
            if (slot_inc >= len_q) begin
              entry_o.two = 1'b1;
              res_b.value = ~sum_add;
              res_b.last  = 1'b1;
              phase_d     = PH_IDLE;
            end
          end
        end
        REQ_START_READ: begin
          enq_o       = 1'b1;
          res_a.value = {1'b0, reg_addr_i};
          sum_d       = {1'b0, reg_addr_i};
          len_d       = len_sat;
          slot_d      = '0;
          wait_d      = '0;
          phase_d     = PH_READ;
        end
        REQ_RX_BYTE: begin
          if (phase_q == PH_READ) begin
            enq_o  = 1'b1;
            wait_d = '0;
            if (slot_q < len_q) begin
              res_a.kind  = KIND_RX_DATA;
              res_a.value = data_byte_i;
              res_a.index = slot_q[1:0];
              sum_d       = sum_add;
              slot_d      = slot_inc;
            end else begin
              res_a.kind   = KIND_FINISHED;
              res_a.status = (data_byte_i == ~sum_q) ? ST_OK : ST_MISMATCH;
              res_a.last   = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
        end
        REQ_TICK: begin
          if (phase_q == PH_READ) begin
            if (wait_q < timeout_q) begin
              wait_d = wait_q + 10'd1;
            end else begin
              enq_o  = 1'b1;
              wait_d = '0;
              if (slot_q < len_q) begin
                res_a.kind  = KIND_MISSED;
                res_a.index = slot_q[1:0];
                slot_d      = slot_inc;
              end else begin
                res_a.kind   = KIND_FINISHED;
                res_a.status = ST_TIMEOUT;
                res_a.last   = 1'b1;
                phase_d      = PH_IDLE;
              end
            end
          end
        end
        default: begin
          // unused request codes are dropped
        end
      endcase
      entry_o.first  = res_a;
      entry_o.second = res_b;
    end
  end

endmodule

// ===== design/srfe_fifo.sv =====
module srfe_fifo import srfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  entry_t    wr_data_i,
  input  logic      rd_i,
  output entry_t    rd_data_o,
  output q_status_t status_o
);

  entry_t         mem_q [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   count_q;
  logic           do_wr, do_rd;

  assign status_o.full  = (count_q == QAw'(0) + (QAw+1)'(QDepth));
  assign status_o.empty = (count_q == '0);
  assign do_wr          = wr_i && !status_o.full;
  assign do_rd          = rd_i && !status_o.empty;
  assign rd_data_o      = mem_q[rptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + QAw'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + QAw'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + (QAw+1)'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - (QAw+1)'(1);
      end
    end
  end

endmodule

// ===== design/srfe_back.sv =====
module srfe_back import srfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  entry_t    head_i,
  input  q_status_t q_status_i,
  output logic      deq_o,
  input  logic      pop,
  output logic      empty,
  output result_t   result_o
);

  logic    out_valid_q;
  result_t out_q;
  logic    sel_q;
  logic    take;
  logic    load;

  // Output register frees when empty or when its result is popped
  assign take     = !out_valid_q || pop;
  assign load     = take && !q_status_i.empty;
  assign deq_o    = load && (!head_i.two || sel_q);
  assign empty    = !out_valid_q;
  assign result_o = out_q;

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= sel_q ? head_i.second : head_i.first;
    end
  end

  // Output valid and second-result select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q <= !q_status_i.empty;
      end
      if (load) begin
        sel_q <= !deq_o;
      end
    end
  end

endmodule

// ===== design/srfe_checker.sv =====
module srfe_checker import srfe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] result_kind_o,
  input logic [7:0] byte_value_o,
  input logic [1:0] byte_index_o,
  input logic [1:0] read_status_o,
  input logic       last_o
);

  // A held result does not change until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_kind_o) && $stable(byte_value_o)
      && $stable(byte_index_o) && $stable(read_status_o) && $stable(last_o))
    else $error("result changed while held");

  // Only a finish carries a real read status
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((result_kind_o == KIND_FINISHED) == (read_status_o != ST_NONE)))
    else $error("read status inconsistent with result kind");

  // last marks a checksum transmit or a finish
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o |-> (result_kind_o == KIND_TX_BYTE || result_kind_o == KIND_FINISHED))
    else $error("last on wrong result kind");

  // Missed slots and finishes carry no byte
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && (result_kind_o == KIND_MISSED || result_kind_o == KIND_FINISHED)
      |-> byte_value_o == 8'd0)
    else $error("nonzero byte on missed or finish");

endmodule

bind serial_register_frame_engine srfe_checker u_chk (.*);
